FILE: hw/rtl/linear_to_srgb8_pixel_encoder_macros.svh
`ifndef LINEAR_TO_SRGB8_PIXEL_ENCODER_MACROS_SVH
`define LINEAR_TO_SRGB8_PIXEL_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSRGB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lsrgb_pkg.sv
package lsrgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 24;
  localparam int GAIN_W    = 24;
  localparam int PROD_W    = IN_W + GAIN_W;
  localparam int MAG_W     = 2 * FRAC_BITS;
  localparam int CODE_W    = 8;
  localparam int NCODES    = 1 << CODE_W;
  localparam int NLANES    = 3;
  localparam int NSTG      = 2 + CODE_W;
  localparam int BIG_W     = 5 * MAG_W + 176;

  localparam int LANE_R = 0;
  localparam int LANE_G = 1;
  localparam int LANE_B = 2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << FRAC_BITS;

  typedef logic [BIG_W-1:0] big_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef mag_t thr_tab_t [NCODES];

  typedef logic [NLANES-1:0][IN_W-1:0]   sample_t;
  typedef logic [NLANES-1:0][PROD_W-1:0] prod_t;

  typedef struct packed {
    logic [NLANES-1:0][MAG_W-1:0]  mag;
    logic [NLANES-1:0][CODE_W-1:0] code;
  } srch_t;

  // True when the encoded code of magnitude up is at least k.
  function automatic logic code_reached(mag_t up, int unsigned k, big_t rhs);
    big_t one_b;
    big_t lhs;
    big_t lin_l;
    big_t lin_r;
    int   i;
    one_b = big_t'(1) << MAG_W;
    lin_l = big_t'(up) * big_t'(10000000);
    lin_r = big_t'(31308) * one_b;
    if (lin_l <= lin_r) begin
      lin_l = big_t'(up) * big_t'(65892) + big_t'(10) * one_b;
      lin_r = big_t'(20 * k) * one_b;
      return lin_l >= lin_r;
    end
    lhs = big_t'(1);
    for (i = 0; i < 5; i++) begin
      lhs = lhs * big_t'(up);
    end
    for (i = 0; i < 12; i++) begin
      lhs = lhs * big_t'(10761);
    end
    return lhs >= rhs;
  endfunction

  // Smallest magnitude whose code is at least k.
  function automatic mag_t code_threshold(int unsigned k);
    big_t           rhs;
    logic [MAG_W:0] lo;
    logic [MAG_W:0] hi;
    logic [MAG_W:0] mid;
    int             i;
    rhs = big_t'(1);
    for (i = 0; i < 12; i++) begin
      rhs = rhs * big_t'(40 * k + 541);
    end
    rhs = rhs << (5 * MAG_W);
    lo  = '0;
    hi  = {1'b0, {MAG_W{1'b1}}};
    for (i = 0; i <= MAG_W; i++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (code_reached(mid[MAG_W-1:0], k, rhs)) begin
          hi = mid;
        end else begin
          lo = mid + 1'b1;
        end
      end
    end
    return lo[MAG_W-1:0];
  endfunction

  function automatic thr_tab_t build_thresholds();
    thr_tab_t t;
    int       k;
    for (k = 0; k < NCODES; k++) begin
      t[k] = code_threshold(k);
    end
    return t;
  endfunction

  localparam thr_tab_t CODE_THR = build_thresholds();

endpackage

FILE: hw/rtl/lsrgb_if.sv
interface lsrgb_in_if;
  import lsrgb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] red_linear;
  logic signed [IN_W-1:0] green_linear;
  logic signed [IN_W-1:0] blue_linear;

  modport source (output valid, output red_linear, output green_linear,
                  output blue_linear, input ready);
  modport sink   (input valid, input red_linear, input green_linear,
                  input blue_linear, output ready);
endinterface

interface lsrgb_out_if;
  import lsrgb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] red_code;
  logic [CODE_W-1:0] green_code;
  logic [CODE_W-1:0] blue_code;

  modport source (output valid, output red_code, output green_code,
                  output blue_code, input ready);
  modport sink   (input valid, input red_code, input green_code,
                  input blue_code, output ready);
endinterface

FILE: hw/rtl/lsrgb_gain_mul.sv
module lsrgb_gain_mul (
  input  logic                            clk,
  input  logic                            en,
  input  logic [lsrgb_pkg::GAIN_W-1:0]    gain,
  input  lsrgb_pkg::sample_t              samples,
  output lsrgb_pkg::prod_t                prod
);
  import lsrgb_pkg::*;

  prod_t prod_r;
  prod_t prod_nxt;
  logic signed [PROD_W-1:0] full [NLANES];

  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      full[l]     = $signed(samples[l]) * $signed({1'b0, gain});
      prod_nxt[l] = full[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

FILE: hw/rtl/lsrgb_clamp.sv
module lsrgb_clamp (
  input  logic               clk,
  input  logic               en,
  input  lsrgb_pkg::prod_t   prod,
  output lsrgb_pkg::srch_t   dout
);
  import lsrgb_pkg::*;

  srch_t dout_r;
  srch_t dout_nxt;
  logic  neg;
  logic  sat;

  always_comb begin
    dout_nxt = '0;
    neg      = 1'b0;
    sat      = 1'b0;
    for (int l = 0; l < NLANES; l++) begin
      neg = prod[l][PROD_W-1] || (prod[l] == '0);
      sat = !prod[l][PROD_W-1] && (|prod[l][PROD_W-1:MAG_W]);
      if (neg) begin
        dout_nxt.mag[l] = '0;
      end else if (sat) begin
        dout_nxt.mag[l] = '1;
      end else begin
        dout_nxt.mag[l] = prod[l][MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

FILE: hw/rtl/lsrgb_search_step.sv
module lsrgb_search_step (
  input  logic                          clk,
  input  logic                          en,
  input  logic [lsrgb_pkg::CODE_W-1:0]  step_bit,
  input  lsrgb_pkg::srch_t              din,
  output lsrgb_pkg::srch_t              dout
);
  import lsrgb_pkg::*;

  srch_t             dout_r;
  srch_t             dout_nxt;
  logic [CODE_W-1:0] cand [NLANES];

  always_comb begin
    dout_nxt = din;
    for (int l = 0; l < NLANES; l++) begin
      cand[l] = din.code[l] | step_bit;
      if (din.mag[l] >= CODE_THR[cand[l]]) begin
        dout_nxt.code[l] = cand[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

FILE: hw/rtl/linear_to_srgb8_pixel_encoder.sv
// Channel   Direction  Payload
// in_px     sink       red_linear, green_linear, blue_linear (signed Q7.16)
// out_px    source     red_code, green_code, blue_code (8-bit sRGB)
// cfg       write      cfg_wdata: exposure gain, unsigned Q8.16
//
// One pixel is accepted per cycle unless a stalled output has filled every stage.
// The ten stages are the gain multiply, the clamp, and one stage per code bit of a
// binary search over a 256-entry threshold table.
// Reset clears all stage valid bits and sets the gain to unity.
// Each stage advances when it is empty or the next stage advances, so bubbles close up
// and a stalled output still lets new transactions fill the empty stages.
module linear_to_srgb8_pixel_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lsrgb_pkg::GAIN_W-1:0]  cfg_wdata,
  lsrgb_in_if.sink                      in_px,
  lsrgb_out_if.source                   out_px
);
  import lsrgb_pkg::*;
  `include "linear_to_srgb8_pixel_encoder_macros.svh"

  logic [GAIN_W-1:0] gain_r;
  logic [NSTG-1:0]   valid_r;
  logic [NSTG-1:0]   valid_nxt;
  logic [NSTG-1:0]   en;
  sample_t           samples;
  prod_t             prod;
  srch_t             srch [CODE_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  assign en[NSTG-1] = !valid_r[NSTG-1] || out_px.ready;

  for (genvar s = 0; s < NSTG - 1; s++) begin : g_en
    assign en[s] = !valid_r[s] || en[s+1];
  end

  always_comb begin
    valid_nxt[0] = en[0] ? in_px.valid : valid_r[0];
    for (int s = 1; s < NSTG; s++) begin
      valid_nxt[s] = en[s] ? valid_r[s-1] : valid_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign samples[LANE_R] = in_px.red_linear;
  assign samples[LANE_G] = in_px.green_linear;
  assign samples[LANE_B] = in_px.blue_linear;

  lsrgb_gain_mul u_mul (
    .clk     (clk),
    .en      (en[0]),
    .gain    (gain_r),
    .samples (samples),
    .prod    (prod)
  );

  lsrgb_clamp u_clamp (
    .clk  (clk),
    .en   (en[1]),
    .prod (prod),
    .dout (srch[0])
  );

  for (genvar j = 0; j < CODE_W; j++) begin : g_step
    lsrgb_search_step u_step (
      .clk      (clk),
      .en       (en[2+j]),
      .step_bit (CODE_W'(1) << (CODE_W - 1 - j)),
      .din      (srch[j]),
      .dout     (srch[j+1])
    );
  end

  assign in_px.ready       = en[0];
  assign out_px.valid      = valid_r[NSTG-1];
  assign out_px.red_code   = srch[CODE_W].code[LANE_R];
  assign out_px.green_code = srch[CODE_W].code[LANE_G];
  assign out_px.blue_code  = srch[CODE_W].code[LANE_B];

  `LSRGB_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_px.valid && in_px.ready, valid_r[0],
    "accepted transaction did not enter the first stage")
  `LSRGB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_px.valid && !out_px.ready,
    out_px.valid && $stable(srch[CODE_W]), "stalled result changed or vanished")
  `LSRGB_ASSERT_NEXT(a_neg_zero, clk, rst_n, valid_r[0] && en[1] && prod[LANE_R][PROD_W-1],
    srch[0].mag[LANE_R] == '0, "negative product not clamped to zero")
  `LSRGB_ASSERT_IMPLY(a_full_block, clk, rst_n, !in_px.ready, (&valid_r) && !out_px.ready,
    "input blocked while the pipeline has room")

endmodule
